FILE: design/olst_pkg.sv
package olst_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Action codes carried in the request beat.
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_INSERT     = 3'd2;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [2:0] ACT_POP_BACK   = 3'd4;
   localparam logic [2:0] ACT_REMOVE     = 3'd5;

   // Status codes carried in the response beat.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  position;
      logic [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] count;
   } rsp_item_type;

   // Broadcast controls shared by every cell of the chain.
   typedef struct packed {
      logic insert;    // open a gap at the slot and load the word there
      logic drop;      // close the gap where the hit chain is set
      logic match_en;  // cells compare their word against the search word
   } cell_ctrl_type;

endpackage

FILE: design/olst_cell.sv
module olst_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  olst_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       slot,
   input  logic [CNT_W-1:0]       count,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   input  logic                   hit_in,
   output logic                   hit_out,
   output logic [DATA_WIDTH-1:0]  data
);
   import olst_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  match;

   // Only occupied cells may claim a match; the hit ripples toward the back.
   assign match   = ctrl.match_en && (MY_IDX < count) && (data_ff == word);
   assign hit_out = hit_in | match;

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (MY_IDX > slot) begin
            data_in = left_data;
         end else if (MY_IDX == slot) begin
            data_in = word;
         end
      end else if (ctrl.drop && hit_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: design/ordered_list_engine.sv
// Channel   Direction  Handshake            Beat contents
// req_*     in         req_valid/req_stall  action, position, value
// rsp_*     out        rsp_valid/rsp_stall  status, count after the action
//
// The row of cells shifts, loads or holds at the edge where the beat is
// accepted. The response register loads at that same edge, so the response
// beat is offered from the next cycle on. A new request is taken in every
// cycle while responses drain.
// Reset clears the element count and the response valid; the cell words
// are left as they are. A stalled response holds and stalls the request
// side until it is taken.
module ordered_list_engine #(
   parameter int CAPACITY   = olst_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = olst_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  olst_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output olst_pkg::rsp_item_type rsp_item
);
   import olst_pkg::*;

   // Count width holds CAPACITY itself; the compare width also covers the
   // four bit position field.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_item_type          rsp_item_ff;
   rsp_item_type          rsp_item_in;

   logic                  go;
   logic                  full;
   logic                  empty;
   logic [DATA_WIDTH-1:0] word;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      pos_next;
   logic [CNT_W-1:0]      slot;
   logic [2:0]            status;
   cell_ctrl_type         ctrl;
   logic                  chain_start;
   logic                  any_hit;
   logic [4:0]            cnt_in_lo;
   logic [4:0]            cnt_ff_lo;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic                  hit [CAPACITY+1];

   assign go    = req_valid && !req_stall;
   assign full  = (cnt_ff == CAP_CNT);
   assign empty = (cnt_ff == '0);

   // The data word is the low DATA_WIDTH bits of value, zero-padded past 32.
   generate
      if (DATA_WIDTH <= 32) begin : g_word_narrow
         assign word = req_item.value[DATA_WIDTH-1:0];
      end else begin : g_word_wide
         assign word = {{(DATA_WIDTH-32){1'b0}}, req_item.value};
      end
      if (CNT_W >= 5) begin : g_cnt_wide
         assign cnt_in_lo = cnt_in[4:0];
         assign cnt_ff_lo = cnt_ff[4:0];
      end else begin : g_cnt_narrow
         assign cnt_in_lo = {{(5-CNT_W){1'b0}}, cnt_in};
         assign cnt_ff_lo = {{(5-CNT_W){1'b0}}, cnt_ff};
      end
   endgenerate

   assign pos_ext  = CMP_W'(req_item.position);
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign pos_next = pos_ext + CMP_W'(1);

   // Decode the action. Cell controls are gated by the accept so the row
   // holds while no beat is taken. The search (match_en) runs ungated so the
   // hit result is known before the drop decision.
   always_comb begin
      status         = ST_OK;
      cnt_in         = cnt_ff;
      slot           = '0;
      ctrl.insert    = 1'b0;
      ctrl.drop      = 1'b0;
      ctrl.match_en  = 1'b0;
      chain_start    = 1'b0;
      case (req_item.action)
         ACT_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = go;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
         end
         ACT_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = go;
               slot        = cnt_ff;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
         end
         ACT_INSERT: begin
            // The range check comes before the fullness check.
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = go;
               slot        = pos_next[CNT_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               // Seeding the hit chain shifts every cell toward the front.
               chain_start = 1'b1;
               ctrl.drop   = go;
               cnt_in      = cnt_ff - CNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            ctrl.match_en = 1'b1;
            if (empty) begin
               status = ST_EMPTY;
            end else if (!any_hit) begin
               status = ST_NOTFOUND;
            end else begin
               ctrl.drop = go;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            // Unused action codes leave the list alone and report ok.
         end
      endcase
   end

   // The hit chain enters at the front cell and leaves past the back cell;
   // for a removal its last stage tells whether any occupied cell matched.
   assign hit[0]  = chain_start;
   assign any_hit = hit[CAPACITY];

   generate
      for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_w;
         logic [DATA_WIDTH-1:0] right_w;
         if (k == 0) begin : g_first
            assign left_w = word;
         end else begin : g_mid_l
            assign left_w = cell_data[k-1];
         end
         if (k == CAPACITY - 1) begin : g_last
            assign right_w = word;
         end else begin : g_mid_r
            assign right_w = cell_data[k+1];
         end
         olst_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (k)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .slot       (slot),
            .count      (cnt_ff),
            .word       (word),
            .left_data  (left_w),
            .right_data (right_w),
            .hit_in     (hit[k]),
            .hit_out    (hit[k+1]),
            .data       (cell_data[k])
         );
      end
   endgenerate

   // The response register frees itself when its beat is taken, so the
   // request side only stalls while a response is held back.
   assign req_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (go) begin
         rsp_valid_in       = 1'b1;
         rsp_item_in.status = status;
         rsp_item_in.count  = cnt_in_lo;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            cnt_ff <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The element count never passes the capacity of the cell row.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_CNT)
      else $error("element count above capacity");

   // Every accepted request beat leaves a response waiting.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("accepted request gave no response");

   // A held response reports the count that the list now holds.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.count == cnt_ff_lo))
      else $error("response count differs from list count");

   // A full status is only given while the row is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.status == ST_FULL)) |-> (cnt_ff == CAP_CNT))
      else $error("full status while not full");

   // A successful front push grows the list by one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (go && (req_item.action == ACT_PUSH_FRONT) && !full)
      |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("front push did not grow the list");

endmodule

FILE: dv/ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_tb;
   import olst_pkg::*;

   // The two action codes that the block must treat as no-ops.
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam int LIST_DEPTH   = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1300;

   // Cycle window in which neither side idles, and the points at which the
   // long receiver hold-off and the sender drain pause are triggered.
   localparam int unsigned BUSY_FROM    = 800;
   localparam int unsigned BUSY_TO      = 1200;
   localparam int unsigned HOLD_AT_RSP  = 250;
   localparam int unsigned HOLD_CYCLES  = 70;
   localparam int unsigned PAUSE_AT_REQ = 700;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   ordered_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Requests waiting to be offered, and the responses predicted for the
   // requests that the block has already taken, oldest first.
   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   rsp_item_type predicted_rsp;
   rsp_item_type wanted_rsp;

   // Shadow copy of the list contents; entry 0 is the front.
   logic [31:0]  list_words[LIST_DEPTH];
   int unsigned  list_len = 0;

   int unsigned  cycle_no    = 0;
   int unsigned  beats_sent  = 0;
   int unsigned  rsps_seen   = 0;
   int unsigned  mismatches  = 0;
   int unsigned  hold_left   = 0;
   bit           drain_pause = 1'b0;

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // Random idling on either side, suppressed inside the busy window so that
   // the block also sees a long run of back-to-back beats.
   function automatic bit take_idle();
      if (cycle_no >= BUSY_FROM && cycle_no <= BUSY_TO) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 27;
   endfunction

   // Applies one request to the shadow list and returns the response that
   // the block should give for it. Inserting opens a gap by shifting the
   // later words up; dropping closes it by shifting them down.
   task automatic apply_list_action(input req_item_type r, output rsp_item_type o);
      logic [2:0] st;
      int         hit;
      int         slot;
      st   = ST_OK;
      hit  = -1;
      slot = 0;
      case (r.action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
            // An insert checks its position before it checks for room.
            if (r.action == ACT_INSERT && r.position >= list_len) begin
               st = ST_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
               st = ST_FULL;
            end else begin
               if (r.action == ACT_PUSH_FRONT) slot = 0;
               else if (r.action == ACT_PUSH_BACK) slot = list_len;
               else slot = r.position + 1;
               for (int k = list_len; k > slot; k--) list_words[k] = list_words[k - 1];
               list_words[slot] = r.value;
               list_len++;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else begin
               if (r.action == ACT_POP_FRONT) begin
                  hit = 0;
               end else if (r.action == ACT_POP_BACK) begin
                  hit = list_len - 1;
               end else begin
                  // Only the first match counted from the front goes.
                  for (int k = 0; k < list_len; k++) begin
                     if (hit < 0 && list_words[k] == r.value) hit = k;
                  end
               end
               if (hit < 0) begin
                  st = ST_NOTFOUND;
               end else begin
                  for (int k = hit; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
                  list_len--;
               end
            end
         end
         default: begin
         end
      endcase
      o.status = st;
      o.count  = 5'(list_len);
   endtask

   task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at response %0d: %s expected %0d actual %0d",
                  rsps_seen, what, want, got);
      end
   endtask

   function automatic req_item_type make_req(input logic [2:0] act, input logic [3:0] pos,
                                             input logic [31:0] val);
      req_item_type r;
      r.action   = act;
      r.position = pos;
      r.value    = val;
      return r;
   endfunction

   // Request driver. A beat that has been offered stays on the bus until it
   // is taken; only then may the driver idle, pause, or load the next one.
   // The prediction is made at the edge where the beat is accepted, so the
   // shadow list always follows the order in which the block saw requests.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_list_action(req_item, predicted_rsp);
            expected_rsps.push_back(predicted_rsp);
            beats_sent++;
            if (beats_sent == PAUSE_AT_REQ) drain_pause = 1'b1;
         end
         if (!req_valid || !req_stall) begin
            // During the drain pause the sender waits until every response
            // that is owed has come back before it offers anything new.
            if (drain_pause && expected_rsps.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               drain_pause = 1'b0;
               if (pending_reqs.size() == 0 || take_idle()) begin
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_item  <= pending_reqs.pop_front();
               end
            end
         end
      end
   end

   // Response monitor and stall generator. Each accepted response beat is
   // checked against the oldest prediction. Once, the receiver holds off for
   // a long stretch so that the block backs up and stalls its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               flag_mismatch("unexpected beat, status", 0, rsp_item.status);
            end else begin
               wanted_rsp = expected_rsps.pop_front();
               if (rsp_item.status !== wanted_rsp.status) begin
                  flag_mismatch("status", wanted_rsp.status, rsp_item.status);
               end
               if (rsp_item.count !== wanted_rsp.count) begin
                  flag_mismatch("count", wanted_rsp.count, rsp_item.count);
               end
            end
            if (rsps_seen == HOLD_AT_RSP) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= take_idle();
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int unsigned push_pct;
      int unsigned pick;
      logic [2:0]  act;
      logic [3:0]  pos;
      logic [31:0] val;

      // Directed opening: every action but the back push on an empty list,
      // the spare codes, the extreme data words, inserts out of range and after
      // the last element, a remove that misses and one that has two candidates.
      pending_reqs.push_back(make_req(ACT_POP_FRONT,  4'd0,  $urandom));
      pending_reqs.push_back(make_req(ACT_POP_BACK,   4'd15, $urandom));
      pending_reqs.push_back(make_req(ACT_REMOVE,     4'd0,  32'd0));
      pending_reqs.push_back(make_req(ACT_INSERT,     4'd0,  32'h1234_5678));
      pending_reqs.push_back(make_req(ACT_SPARE_LO,   4'd15, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_SPARE_HI,   4'd0,  32'd0));
      pending_reqs.push_back(make_req(ACT_PUSH_FRONT, 4'd0,  32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_PUSH_BACK,  4'd15, 32'd0));
      pending_reqs.push_back(make_req(ACT_INSERT,     4'd15, 32'hA5A5_A5A5));
      pending_reqs.push_back(make_req(ACT_INSERT,     4'd1,  32'h0000_00A1));
      pending_reqs.push_back(make_req(ACT_INSERT,     4'd0,  32'h0000_00B2));
      pending_reqs.push_back(make_req(ACT_SPARE_LO,   4'd3,  $urandom));
      pending_reqs.push_back(make_req(ACT_REMOVE,     4'd0,  32'h0BAD_F00D));
      pending_reqs.push_back(make_req(ACT_PUSH_BACK,  4'd0,  32'h0000_00B2));
      pending_reqs.push_back(make_req(ACT_REMOVE,     4'd0,  32'h0000_00B2));
      pending_reqs.push_back(make_req(ACT_REMOVE,     4'd0,  32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_POP_FRONT,  4'd7,  $urandom));
      pending_reqs.push_back(make_req(ACT_POP_BACK,   4'd8,  $urandom));
      pending_reqs.push_back(make_req(ACT_POP_BACK,   4'd0,  $urandom));
      pending_reqs.push_back(make_req(ACT_POP_BACK,   4'd0,  $urandom));
      pending_reqs.push_back(make_req(ACT_SPARE_HI,   4'd9,  $urandom));

      // Random part in runs of forty beats. Each run leans towards filling,
      // draining or churning the list, so both the full and the empty
      // corners are reached many times. Small data values make repeats
      // likely, which gives removes something to find.
      push_pct = 52;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 75;
               1:       push_pct = 25;
               default: push_pct = 52;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         else if (pick < push_pct) act = 3'($urandom_range(ACT_PUSH_FRONT, ACT_INSERT));
         else act = 3'($urandom_range(ACT_POP_FRONT, ACT_REMOVE));
         pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
         val = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : 32'($urandom);
         pending_reqs.push_back(make_req(act, pos, val));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Checks happen on the falling edge, away from the edge where the
      // driver and the monitor update the queues.
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0 ||
             drain_pause) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: ordered_list_engine.f
design/olst_pkg.sv
design/olst_cell.sv
design/ordered_list_engine.sv
dv/ordered_list_engine_tb.sv
